// ----- rtl/m4inv_pkg.sv -----
// Package for the 4x4 fixed-point matrix inverse block.
// Widths, codes, types and saturating helpers shared by all rtl/m4inv_* files.
// No dependencies.
package m4inv_pkg;

  localparam int ELEM_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int INT_W       = 64;
  localparam int HALF_W      = INT_W / 2;
  localparam int PROD_W      = ELEM_W + INT_W;
  localparam int PART_W      = ELEM_W + HALF_W;
  localparam int NUM_W       = INT_W + FRAC_BITS;
  localparam int THR_W       = 31;
  localparam int IDX_W       = 4;
  localparam int N_ELEM      = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic REG_THRESHOLD = 1'b0;

  typedef logic signed [INT_W-1:0] int_t;

  localparam int_t SAT_MAX = {1'b0, {(INT_W-1){1'b1}}};

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic [IDX_W-1:0]  index;
    logic              last;
  } elem_entry_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_RD, ST_MLO, ST_MHI, ST_RND, ST_ACC,
    ST_CHECK, ST_OUT_RD, ST_OUT_WAIT, ST_DIV
  } back_state_t;

  typedef enum logic [2:0] {
    POST_T, POST_S, POST_D_SET, POST_D_SUB, POST_D_ADD
  } post_t;

  typedef struct packed {
    logic [1:0] ar;
    logic [1:0] ac;
    logic [1:0] br;
    logic [1:0] bc;
    logic       b_acc;
    post_t      post;
  } mul_op_t;

  typedef struct packed {
    logic start;
    int_t num;
    int_t den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ELEM_W-1:0] quotient;
  } div_rsp_t;

  localparam logic [3:0] LAST_OP = 4'd8;

  // 3x3 determinant schedule: two minors products, their difference, then the
  // row-0 term folded into the running sum.
  function automatic mul_op_t mul_op(input logic [3:0] n);
    mul_op_t o;
    o = mul_op_t'('0);
    case (n)
      4'd0: o = '{ar: 2'd1, ac: 2'd1, br: 2'd2, bc: 2'd2, b_acc: 1'b0, post: POST_T};
      4'd1: o = '{ar: 2'd1, ac: 2'd2, br: 2'd2, bc: 2'd1, b_acc: 1'b0, post: POST_S};
      4'd2: o = '{ar: 2'd0, ac: 2'd0, br: 2'd0, bc: 2'd0, b_acc: 1'b1, post: POST_D_SET};
      4'd3: o = '{ar: 2'd1, ac: 2'd0, br: 2'd2, bc: 2'd2, b_acc: 1'b0, post: POST_T};
      4'd4: o = '{ar: 2'd1, ac: 2'd2, br: 2'd2, bc: 2'd0, b_acc: 1'b0, post: POST_S};
      4'd5: o = '{ar: 2'd0, ac: 2'd1, br: 2'd0, bc: 2'd0, b_acc: 1'b1, post: POST_D_SUB};
      4'd6: o = '{ar: 2'd1, ac: 2'd0, br: 2'd2, bc: 2'd1, b_acc: 1'b0, post: POST_T};
      4'd7: o = '{ar: 2'd1, ac: 2'd1, br: 2'd2, bc: 2'd0, b_acc: 1'b0, post: POST_S};
      4'd8: o = '{ar: 2'd0, ac: 2'd2, br: 2'd0, bc: 2'd0, b_acc: 1'b1, post: POST_D_ADD};
      default: o = mul_op_t'('0);
    endcase
    return o;
  endfunction

  // minor row/column to full-matrix row/column, skipping the removed one
  function automatic logic [1:0] skip(input logic [1:0] n, input logic [1:0] x);
    return (n >= x) ? n + 2'd1 : n;
  endfunction

  function automatic logic [INT_W-1:0] mag_int(input int_t v);
    return v[INT_W-1] ? -v : v;
  endfunction

  function automatic int_t sat_add(input int_t a, input int_t b);
    logic signed [INT_W:0] s;
    s = $signed({a[INT_W-1], a}) + $signed({b[INT_W-1], b});
    if (s > $signed({1'b0, SAT_MAX})) return SAT_MAX;
    else if (s < -$signed({1'b0, SAT_MAX})) return -SAT_MAX;
    return s[INT_W-1:0];
  endfunction

endpackage

// ----- rtl/m4inv_front.sv -----
// Front end: takes elements, tags each with its row-major index and last flag.
// Depends on m4inv_pkg.
module m4inv_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [m4inv_pkg::ELEM_W-1:0]   element_value,
  input  logic                           q_full,
  output logic                           busy,
  output logic                           push,
  output m4inv_pkg::elem_entry_t         entry
);

  logic [m4inv_pkg::IDX_W-1:0] load_count;

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    entry.value = element_value;
    entry.index = load_count;
    entry.last  = (load_count == m4inv_pkg::IDX_W'(m4inv_pkg::N_ELEM - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (push) begin
      load_count <= load_count + 1'b1;
    end
  end

endmodule

// ----- rtl/m4inv_queue.sv -----
// Small flop queue of tagged elements between front and back end.
// Depends on m4inv_pkg.
module m4inv_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  m4inv_pkg::elem_entry_t  wr_entry,
  input  logic                    pop,
  output m4inv_pkg::elem_entry_t  rd_entry,
  output logic                    valid,
  output logic                    full
);

  localparam int PTR_W = $clog2(m4inv_pkg::QUEUE_DEPTH);

  m4inv_pkg::elem_entry_t slots [m4inv_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign valid    = (count != '0);
  assign full     = (count == (PTR_W+1)'(m4inv_pkg::QUEUE_DEPTH));
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ----- rtl/m4inv_div.sv -----
// Restoring divider, one quotient bit per cycle: |num|*2^F / |den|, rounded,
// signed and saturated to the element width. Depends on m4inv_pkg.
module m4inv_div (
  input  logic                  clk,
  input  logic                  rst,
  input  m4inv_pkg::div_req_t   req,
  output m4inv_pkg::div_rsp_t   rsp
);

  localparam int CNT_W = $clog2(m4inv_pkg::NUM_W);
  localparam int EW    = m4inv_pkg::ELEM_W;
  localparam int IW    = m4inv_pkg::INT_W;
  localparam int NW    = m4inv_pkg::NUM_W;

  logic             running;
  logic             finish;
  logic [CNT_W-1:0] cnt;
  logic [IW-1:0]    rem;
  logic [IW-1:0]    dvs;
  logic [NW-1:0]    nsh;
  logic [EW-1:0]    q;
  logic             ovf;
  logic             neg;
  logic             done;
  logic [EW-1:0]    quotient;

  logic [IW-1:0] rem_shift;
  logic          fits;
  logic [EW-1:0] cap;
  logic [EW-1:0] q_sat;

  assign rsp.done     = done;
  assign rsp.quotient = quotient;

  always_comb begin
    rem_shift = {rem[IW-2:0], nsh[NW-1]};
    fits      = (rem_shift >= dvs);
    cap       = neg ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    q_sat     = (ovf || q > cap) ? cap : q;
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs <= m4inv_pkg::mag_int(req.den);
      nsh <= (NW'(m4inv_pkg::mag_int(req.num)) << m4inv_pkg::FRAC_BITS)
             + NW'(m4inv_pkg::mag_int(req.den) >> 1);
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
      neg <= req.num[IW-1] ^ req.den[IW-1];
    end else if (running) begin
      rem <= fits ? rem_shift - dvs : rem_shift;
      nsh <= nsh << 1;
      q   <= {q[EW-2:0], fits};
      ovf <= ovf | q[EW-1];
    end
    if (finish) begin
      quotient <= neg ? -q_sat : q_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      finish  <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done   <= finish;
      finish <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NW - 1)) begin
          running <= 1'b0;
          finish  <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/m4inv_back.sv -----
// Back end: element store, shared multiplier sequencer for cofactors and the
// determinant, cofactor store, divider control and result register.
// Depends on m4inv_pkg and m4inv_div.
module m4inv_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  input  m4inv_pkg::elem_entry_t                q_entry,
  output logic                                  q_pop,
  input  logic [m4inv_pkg::THR_W-1:0]           threshold,
  output logic                                  result_valid,
  output logic signed [m4inv_pkg::ELEM_W-1:0]   result_value,
  output logic [m4inv_pkg::IDX_W-1:0]           result_index,
  output logic                                  singular,
  output logic                                  last_result
);

  localparam int EW = m4inv_pkg::ELEM_W;
  localparam int IW = m4inv_pkg::INT_W;
  localparam int HW = m4inv_pkg::HALF_W;
  localparam int PW = m4inv_pkg::PROD_W;
  localparam int XW = m4inv_pkg::PART_W;
  localparam int AW = m4inv_pkg::IDX_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(m4inv_pkg::N_ELEM - 1);

  m4inv_pkg::back_state_t state, state_next;

  logic [EW-1:0]           store   [m4inv_pkg::N_ELEM];
  m4inv_pkg::int_t         cof_mem [m4inv_pkg::N_ELEM];

  logic [AW-1:0] cof_idx;
  logic [3:0]    op_idx;
  logic [AW-1:0] out_idx;
  logic          det_phase;
  logic          sing;

  logic [EW-1:0]   a_data;
  logic [EW-1:0]   b_data;
  m4inv_pkg::int_t cof_rdata;
  logic [EW-1:0]   mag_a_r;
  logic [HW-1:0]   mag_b_hi;
  logic [XW-1:0]   p_lo;
  logic [XW-1:0]   p_hi;
  logic            prod_neg;
  m4inv_pkg::int_t prod;
  m4inv_pkg::int_t t_reg;
  m4inv_pkg::int_t s_reg;
  m4inv_pkg::int_t d_reg;
  m4inv_pkg::int_t det;

  m4inv_pkg::mul_op_t cur_op;
  logic [AW-1:0]      rd_a_addr;
  logic [AW-1:0]      rd_b_addr;
  logic [AW-1:0]      cof_addr;
  m4inv_pkg::int_t    b_full;
  logic [EW-1:0]      mag_a;
  logic [IW-1:0]      mag_b;
  logic [PW-1:0]      full_prod;
  logic [PW-1:0]      shifted;
  logic [IW-1:0]      prod_mag;
  m4inv_pkg::int_t    d_fin;
  m4inv_pkg::int_t    cof_final;

  logic store_we;
  logic cof_we;
  logic emit_sing;
  logic emit_div;
  logic last_op;

  m4inv_pkg::div_req_t div_req;
  m4inv_pkg::div_rsp_t div_rsp;

  m4inv_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    cur_op    = m4inv_pkg::mul_op(op_idx);
    last_op   = det_phase ? (op_idx[1:0] == 2'd3) : (op_idx == m4inv_pkg::LAST_OP);
    if (state == m4inv_pkg::ST_OUT_RD) begin
      rd_a_addr = out_idx;
      cof_addr  = {out_idx[1:0], out_idx[3:2]};
    end else if (det_phase) begin
      rd_a_addr = {2'b00, op_idx[1:0]};
      cof_addr  = {2'b00, op_idx[1:0]};
    end else begin
      rd_a_addr = {m4inv_pkg::skip(cur_op.ar, cof_idx[3:2]),
                   m4inv_pkg::skip(cur_op.ac, cof_idx[1:0])};
      cof_addr  = {2'b00, op_idx[1:0]};
    end
    rd_b_addr = {m4inv_pkg::skip(cur_op.br, cof_idx[3:2]),
                 m4inv_pkg::skip(cur_op.bc, cof_idx[1:0])};

    if (det_phase)         b_full = cof_rdata;
    else if (cur_op.b_acc) b_full = s_reg;
    else                   b_full = {{(IW-EW){b_data[EW-1]}}, b_data};
    mag_a = a_data[EW-1] ? -a_data : a_data;
    mag_b = m4inv_pkg::mag_int(b_full);

    full_prod = {{HW{1'b0}}, p_lo} + {p_hi, {HW{1'b0}}}
                + (PW'(1) << (m4inv_pkg::FRAC_BITS - 1));
    shifted   = full_prod >> m4inv_pkg::FRAC_BITS;
    prod_mag  = (|shifted[PW-1:IW-1]) ? m4inv_pkg::SAT_MAX : shifted[IW-1:0];

    d_fin     = m4inv_pkg::sat_add(d_reg, prod);
    cof_final = (cof_idx[2] ^ cof_idx[0]) ? -d_fin : d_fin;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      m4inv_pkg::ST_LOAD:     if (q_valid && q_entry.last) state_next = m4inv_pkg::ST_RD;
      m4inv_pkg::ST_RD:       state_next = m4inv_pkg::ST_MLO;
      m4inv_pkg::ST_MLO:      state_next = m4inv_pkg::ST_MHI;
      m4inv_pkg::ST_MHI:      state_next = m4inv_pkg::ST_RND;
      m4inv_pkg::ST_RND:      state_next = m4inv_pkg::ST_ACC;
      m4inv_pkg::ST_ACC: begin
        state_next = (det_phase && last_op) ? m4inv_pkg::ST_CHECK : m4inv_pkg::ST_RD;
      end
      m4inv_pkg::ST_CHECK:    state_next = m4inv_pkg::ST_OUT_RD;
      m4inv_pkg::ST_OUT_RD:   state_next = m4inv_pkg::ST_OUT_WAIT;
      m4inv_pkg::ST_OUT_WAIT: begin
        if (!sing)                 state_next = m4inv_pkg::ST_DIV;
        else if (out_idx == LAST_IDX) state_next = m4inv_pkg::ST_LOAD;
        else                       state_next = m4inv_pkg::ST_OUT_RD;
      end
      m4inv_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_next = (out_idx == LAST_IDX) ? m4inv_pkg::ST_LOAD : m4inv_pkg::ST_OUT_RD;
        end
      end
      default: state_next = m4inv_pkg::ST_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop         = (state == m4inv_pkg::ST_LOAD) && q_valid;
    store_we      = q_pop;
    cof_we        = (state == m4inv_pkg::ST_ACC) && !det_phase && last_op;
    emit_sing     = (state == m4inv_pkg::ST_OUT_WAIT) && sing;
    emit_div      = (state == m4inv_pkg::ST_DIV) && div_rsp.done;
    div_req.start = (state == m4inv_pkg::ST_OUT_WAIT) && !sing;
    div_req.num   = cof_rdata;
    div_req.den   = det;
  end

  always_ff @(posedge clk) begin
    if (store_we) store[q_entry.index] <= q_entry.value;
    if (cof_we)   cof_mem[cof_idx] <= cof_final;
    a_data    <= store[rd_a_addr];
    b_data    <= store[rd_b_addr];
    cof_rdata <= cof_mem[cof_addr];
  end

  always_ff @(posedge clk) begin
    unique case (state)
      m4inv_pkg::ST_MLO: begin
        p_lo     <= mag_a * mag_b[HW-1:0];
        mag_a_r  <= mag_a;
        mag_b_hi <= mag_b[IW-1:HW];
        prod_neg <= a_data[EW-1] ^ b_full[IW-1];
      end
      m4inv_pkg::ST_MHI: p_hi <= mag_a_r * mag_b_hi;
      m4inv_pkg::ST_RND: prod <= prod_neg ? -prod_mag : prod_mag;
      m4inv_pkg::ST_ACC: begin
        if (det_phase) begin
          det <= m4inv_pkg::sat_add(det, prod);
        end else begin
          unique case (cur_op.post)
            m4inv_pkg::POST_T:     t_reg <= prod;
            m4inv_pkg::POST_S:     s_reg <= m4inv_pkg::sat_add(t_reg, -prod);
            m4inv_pkg::POST_D_SET: d_reg <= prod;
            m4inv_pkg::POST_D_SUB: d_reg <= m4inv_pkg::sat_add(d_reg, -prod);
            m4inv_pkg::POST_D_ADD: d_reg <= d_fin;
            default:               d_reg <= d_reg;
          endcase
          if (last_op && cof_idx == LAST_IDX) det <= '0;
        end
      end
      default: ;
    endcase
    if (emit_sing || emit_div) begin
      result_value <= emit_sing ? a_data : div_rsp.quotient;
      result_index <= out_idx;
      singular     <= sing;
      last_result  <= (out_idx == LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= m4inv_pkg::ST_LOAD;
      cof_idx      <= '0;
      op_idx       <= '0;
      out_idx      <= '0;
      det_phase    <= 1'b0;
      sing         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit_sing || emit_div;
      if (q_pop && q_entry.last) begin
        cof_idx   <= '0;
        op_idx    <= '0;
        det_phase <= 1'b0;
      end
      if (state == m4inv_pkg::ST_ACC) begin
        if (!det_phase && last_op) begin
          op_idx  <= '0;
          cof_idx <= cof_idx + 1'b1;
          if (cof_idx == LAST_IDX) det_phase <= 1'b1;
        end else begin
          op_idx <= op_idx + 1'b1;
        end
      end
      if (state == m4inv_pkg::ST_CHECK) begin
        sing    <= (det == '0) ||
                   (m4inv_pkg::mag_int(det) < {{(IW-m4inv_pkg::THR_W){1'b0}}, threshold});
        out_idx <= '0;
      end
      if (emit_sing || emit_div) out_idx <= out_idx + 1'b1;
    end
  end

  a_last_back_to_load: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_result |-> state == m4inv_pkg::ST_LOAD)
    else $error("last result not followed by load");

  a_div_multicycle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> !div_rsp.done)
    else $error("divider done too early");

  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == m4inv_pkg::ST_OUT_WAIT || state == m4inv_pkg::ST_DIV))
    else $error("result outside output phase");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !det_phase || state == m4inv_pkg::ST_LOAD)
    else $error("queue popped during compute");

endmodule

// ----- rtl/matrix4_inverse_adjugate.sv -----
// 4x4 Q16.16 matrix inverse by adjugate. Elements enter one per cycle into a
// 4-deep queue while busy is low; a matrix is then processed by one shared
// 32x32 multiplier (148 products, each through ST_RD, ST_MLO, ST_MHI, ST_RND and
// ST_ACC) and a bit-serial divider, which a singular matrix bypasses.
// Synchronous reset clears control and sets the threshold to 7; stores undefined.
module matrix4_inverse_adjugate (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [m4inv_pkg::ELEM_W-1:0]   element_value,
  output logic                                  result_valid,
  output logic signed [m4inv_pkg::ELEM_W-1:0]   result_value,
  output logic [m4inv_pkg::IDX_W-1:0]           result_index,
  output logic                                  singular,
  output logic                                  last_result,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [m4inv_pkg::PADDR_W-1:0]         paddr,
  input  logic [m4inv_pkg::PDATA_W-1:0]         pwdata,
  output logic [m4inv_pkg::PDATA_W-1:0]         prdata,
  output logic                                  pready
);

  logic [m4inv_pkg::THR_W-1:0] threshold;
  logic                        q_full;
  logic                        q_valid;
  logic                        q_pop;
  logic                        push;
  m4inv_pkg::elem_entry_t      wr_entry;
  m4inv_pkg::elem_entry_t      rd_entry;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == m4inv_pkg::REG_THRESHOLD)
                  ? {{(m4inv_pkg::PDATA_W-m4inv_pkg::THR_W){1'b0}}, threshold} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= m4inv_pkg::THR_W'(7);
    end else if (psel && penable && pwrite && paddr[2] == m4inv_pkg::REG_THRESHOLD) begin
      threshold <= pwdata[m4inv_pkg::THR_W-1:0];
    end
  end

  m4inv_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .element_value (element_value),
    .q_full        (q_full),
    .busy          (busy),
    .push          (push),
    .entry         (wr_entry)
  );

  m4inv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .rd_entry (rd_entry),
    .valid    (q_valid),
    .full     (q_full)
  );

  m4inv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (rd_entry),
    .q_pop        (q_pop),
    .threshold    (threshold),
    .result_valid (result_valid),
    .result_value (result_value),
    .result_index (result_index),
    .singular     (singular),
    .last_result  (last_result)
  );

endmodule

// ----- tb/sv/m4inv_checker.sv -----
// Checker for matrix4_inverse_adjugate: watches element, result and APB transfers,
// predicts the inverse (or pass-through) of every loaded matrix and compares results.
// Depends on m4inv_pkg for widths.
module m4inv_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [m4inv_pkg::ELEM_W-1:0] element_value,
  input  logic                                result_valid,
  input  logic signed [m4inv_pkg::ELEM_W-1:0] result_value,
  input  logic [m4inv_pkg::IDX_W-1:0]         result_index,
  input  logic                                singular,
  input  logic                                last_result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [m4inv_pkg::PADDR_W-1:0]       paddr,
  input  logic [m4inv_pkg::PDATA_W-1:0]       pwdata,
  output int                                  fail_count,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import m4inv_pkg::*;

  localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [PADDR_W-1:0] ADDR_THR = PADDR_W'(REG_THRESHOLD) << 2;

  typedef struct {
    logic [ELEM_W-1:0] value;
    logic [IDX_W-1:0]  index;
    logic              sing;
    logic              last;
  } inv_elem_t;

  inv_elem_t         inverse_q[$];
  int_t              mat[16];
  logic [3:0]        fill;
  logic [THR_W-1:0]  thr;

  assign pending = inverse_q.size();

  function automatic logic [63:0] absval(int_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic int_t q_mul(int_t a, int_t b);
    logic [127:0] p;
    logic [63:0]  m;
    p = {64'd0, absval(a)} * {64'd0, absval(b)};
    p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    m = (p > {64'd0, Q_MAX}) ? Q_MAX : p[63:0];
    return (a[63] ^ b[63]) ? -$signed(m) : $signed(m);
  endfunction

  function automatic int_t q_add(int_t a, int_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > $signed({1'b0, Q_MAX})) return $signed(Q_MAX);
    if (s < -$signed({1'b0, Q_MAX})) return -$signed(Q_MAX);
    return s[63:0];
  endfunction

  function automatic int_t q_sub(int_t a, int_t b);
    return q_add(a, -b);
  endfunction

  function automatic int_t signed_minor(int r, int c);
    int   rr[3], cc[3];
    int   n, k;
    int_t v[3][3];
    int_t d;
    n = 0;
    k = 0;
    for (int i = 0; i < 4; i++) begin
      if (i != r) begin rr[n] = i; n++; end
      if (i != c) begin cc[k] = i; k++; end
    end
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        v[a][b] = mat[rr[a]*4 + cc[b]];
    d = q_mul(v[0][0], q_sub(q_mul(v[1][1], v[2][2]), q_mul(v[1][2], v[2][1])));
    d = q_sub(d, q_mul(v[0][1], q_sub(q_mul(v[1][0], v[2][2]), q_mul(v[1][2], v[2][0]))));
    d = q_add(d, q_mul(v[0][2], q_sub(q_mul(v[1][0], v[2][1]), q_mul(v[1][1], v[2][0]))));
    return ((r + c) % 2) ? -d : d;
  endfunction

  function automatic logic [ELEM_W-1:0] q_div(int_t num, int_t den);
    logic [127:0] n, q, cap;
    logic [63:0]  d;
    logic         neg;
    neg = num[63] ^ den[63];
    d = absval(den);
    n = ({64'd0, absval(num)} << FRAC_BITS) + {64'd0, d >> 1};
    q = n / {64'd0, d};
    cap = neg ? (128'd1 << (ELEM_W - 1)) : (128'd1 << (ELEM_W - 1)) - 1;
    if (q > cap) q = cap;
    return neg ? ELEM_W'(-q) : ELEM_W'(q);
  endfunction

  task automatic predict_matrix();
    int_t      cof[16];
    int_t      det;
    logic      sing;
    inv_elem_t e;
    det = 0;
    for (int i = 0; i < 16; i++) cof[i] = signed_minor(i / 4, i % 4);
    for (int j = 0; j < 4; j++) det = q_add(det, q_mul(mat[j], cof[j]));
    sing = (det == 0) || (absval(det) < {33'd0, thr});
    for (int k = 0; k < 16; k++) begin
      e.value = sing ? ELEM_W'(mat[k]) : q_div(cof[(k % 4)*4 + k/4], det);
      e.index = IDX_W'(k);
      e.sing  = sing;
      e.last  = (k == 15);
      inverse_q.push_back(e);
    end
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    inv_elem_t w;
    if (rst) begin
      fill = 0;
      thr = 7;
      inverse_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_THR) thr = pwdata[THR_W-1:0];
      if (start && !busy) begin
        mat[fill] = int_t'(element_value);
        fill = fill + 1;
        if (fill == 0) predict_matrix();
      end
      if (result_valid) begin
        if (inverse_q.size() == 0) begin
          report("unexpected transfer, index", result_index, 0);
        end else begin
          w = inverse_q.pop_front();
          if (result_value !== w.value) report("value", result_value, w.value);
          if (result_index !== w.index) report("index", result_index, w.index);
          if (singular !== w.sing) report("singular", singular, w.sing);
          if (last_result !== w.last) report("last", last_result, w.last);
        end
      end
    end
  end

endmodule

// ----- tb/sv/tb_matrix4_inverse_adjugate.sv -----
// Top of the matrix4_inverse_adjugate testbench: clock, reset, element stream,
// threshold writes and verdict. Depends on m4inv_pkg, the RTL and m4inv_checker.
module tb_matrix4_inverse_adjugate;
  timeunit 1ns;
  timeprecision 1ps;
  import m4inv_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_THR    = PADDR_W'(REG_THRESHOLD) << 2;
  localparam logic [PADDR_W-1:0] ADDR_UNUSED = 3'd4;
  localparam int  CYCLE_LIMIT = 2_000_000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic clk = 0, rst = 1, start = 0, busy;
  logic signed [ELEM_W-1:0] element_value = '0;
  logic result_valid, singular, last_result, pready;
  logic signed [ELEM_W-1:0] result_value;
  logic [IDX_W-1:0] result_index;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0, prdata;
  int fail_count, pending, cycles = 0;
  logic idle_on = 0;
  logic [31:0] elem_stream[$];

  always #6 clk = ~clk;

  matrix4_inverse_adjugate i_dut (.*);

  m4inv_checker i_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] sgn(int unsigned span);
    return $urandom_range(2*span) - span;
  endfunction

  task automatic add_matrix(int kind);
    logic [31:0] m[16];
    for (int k = 0; k < 16; k++) begin
      case (kind)
        0: m[k] = sgn(4 * ONE);
        1: m[k] = $urandom;
        2: m[k] = (k % 5 == 0) ? sgn(4 * ONE) + ((k % 2) ? -8 * ONE : 8 * ONE) : sgn(ONE);
        3: m[k] = (k >= 4 && k < 8) ? m[k-4] : sgn(4 * ONE);
        default: m[k] = sgn(256);
      endcase
    end
    foreach (m[k]) elem_stream.push_back(m[k]);
  endtask

  task automatic send_items(int n);
    for (int i = 0; i < n; i++) begin
      if (elem_stream.size() == 0) add_matrix($urandom_range(0, 9) < 5 ? 0 :
                                              $urandom_range(1, 4));
      start <= 1;
      element_value <= elem_stream.pop_front();
      @(posedge clk);
      while (busy) @(posedge clk);
      while (idle_on && $urandom_range(0, 99) < 21) begin
        start <= 0;
        @(posedge clk);
      end
    end
    start <= 0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic reg_write(logic [PADDR_W-1:0] a, logic [31:0] d);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] thr_set[6];
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int k = 0; k < 16; k++) elem_stream.push_back((k % 5 == 0) ? ONE : 32'd0);
    for (int k = 0; k < 16; k++)
      elem_stream.push_back(k[0] ? 32'h8000_0000 : (k[1] ? 32'h7FFF_FFFF : 32'hFFFF_FFFF));
    for (int k = 0; k < 16; k++) elem_stream.push_back(32'd0);
    send_items(48);
    drain();
    thr_set = '{32'd0, 32'hFFFF_FFFF, ONE, 32'd1, 32'h7FFF_FFFF, $urandom};
    foreach (thr_set[p]) begin
      reg_write(ADDR_UNUSED, $urandom);
      reg_write(ADDR_THR, thr_set[p]);
      idle_on = (p != 2);
      send_items(p == 5 ? 78 : 68 + p % 3);
      drain();
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- matrix4_inverse_adjugate.f -----
rtl/m4inv_pkg.sv
rtl/m4inv_front.sv
rtl/m4inv_queue.sv
rtl/m4inv_div.sv
rtl/m4inv_back.sv
rtl/matrix4_inverse_adjugate.sv
tb/sv/m4inv_checker.sv
tb/sv/tb_matrix4_inverse_adjugate.sv
